// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the stream find-and-replace block
// Register indexes, configuration widths, the configuration bundle and the
// default sizes handed to the top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Default pattern and replacement capacity in bytes
   localparam int PATTERN_MAX_DEF     = 8;
   localparam int REPLACEMENT_MAX_DEF = 8;

   // Commands held between front and back
   localparam int QUEUE_DEPTH = 4;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_CASE         = 3'd4;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]      pattern_length;
      logic [CSR_DATA_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]      replacement_length;
      logic                  match_case;
   } cfg_type;

endpackage

// ----- rtl/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find-and-replace over a byte stream
// Replaces each non-overlapping occurrence of a configured pattern by a
// configured replacement, holding partial matches and flushing at end of stream.
// ----------------------------------------------------------------------------
// One request byte is taken per clock while req_full is low. The match
// tracker handles it in the cycle it is accepted and hands a command of 1 to
// max(PATTERN_MAX, REPLACEMENT_MAX) bytes to a QUEUE_DEPTH-entry command queue;
// a request that gives no result hands nothing. The output sequencer then
// sends one result per clock from that queue while its output is empty or
// popped. The stream therefore runs at one byte per clock only while each
// request yields at most one result, and bursts from completed matches or
// flushes fill the queue until req_full rises.
// A result is registered in the command queue, then in the output register.
// Configuration is written through csr_write_en, csr_index and csr_wdata;
// write only while no request is in flight. Held bytes need no clearing.
// ----------------------------------------------------------------------------
module stream_find_replace #(
   parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_end_of_stream,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_from_replacement,
   output logic                            rsp_last_of_run
);
   import sfr_pkg::*;

   localparam int CMD_LANES = (PATTERN_MAX > REPLACEMENT_MAX) ?
                              PATTERN_MAX : REPLACEMENT_MAX;
   localparam int CNT_W     = $clog2(CMD_LANES + 1);
   localparam int CMD_W     = 1 + CNT_W + 8 * CMD_LANES;

   cfg_type                cfg;
   logic                   q_full;
   logic                   cmd_push;
   logic                   cmd_rep;
   logic [CNT_W-1:0]       cmd_count;
   logic [8*CMD_LANES-1:0] cmd_data;
   logic                   head_valid;
   logic [CMD_W-1:0]       head_word;
   logic                   deq;

   sfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   sfr_front #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX),
      .CMD_LANES       (CMD_LANES),
      .CNT_W           (CNT_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_push          (req_push),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .cmd_push          (cmd_push),
      .cmd_rep           (cmd_rep),
      .cmd_count         (cmd_count),
      .cmd_data          (cmd_data)
   );

   sfr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  ({cmd_rep, cmd_count, cmd_data}),
      .full       (q_full),
      .pop        (deq),
      .head_valid (head_valid),
      .head_data  (head_word)
   );

   sfr_back #(
      .CMD_LANES (CMD_LANES),
      .CNT_W     (CNT_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_rep             (head_word[CMD_W-1]),
      .head_count           (head_word[CMD_W-2 -: CNT_W]),
      .head_data            (head_word[8*CMD_LANES-1:0]),
      .deq                  (deq),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_from_replacement (rsp_from_replacement),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   assign req_full = q_full;

endmodule

// ----- rtl/sfr_csr.sv -----
// ----------------------------------------------------------------------------
// sfr_csr: configuration registers
// Holds pattern, replacement, their lengths and the case-match switch.
// Writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module sfr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output sfr_pkg::cfg_type                cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      cfg_in.pattern_bytes      = csr_wdata;
            CSR_PATTERN_LENGTH:     cfg_in.pattern_length     = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  cfg_in.replacement_bytes  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_in.replacement_length = csr_wdata[LEN_W-1:0];
            CSR_MATCH_CASE:         cfg_in.match_case         = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes      <= '0;
         cfg_ff.pattern_length     <= LEN_W'(1);
         cfg_ff.replacement_bytes  <= '0;
         cfg_ff.replacement_length <= '0;
         cfg_ff.match_case         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front: match tracker
// Compares each request byte against the pattern, keeps the partial match
// and turns each request into at most one output command: a list of bytes with a
// count and a replacement flag. Requests that give no output push nothing.
// ----------------------------------------------------------------------------
module sfr_front #(
   parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF,
   parameter int CMD_LANES       = (PATTERN_MAX > REPLACEMENT_MAX) ?
                                   PATTERN_MAX : REPLACEMENT_MAX,
   parameter int CNT_W           = $clog2(CMD_LANES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sfr_pkg::cfg_type       cfg,
   input  logic                   req_push,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_end_of_stream,
   input  logic                   q_full,
   output logic                   cmd_push,
   output logic                   cmd_rep,
   output logic [CNT_W-1:0]       cmd_count,
   output logic [8*CMD_LANES-1:0] cmd_data
);
   import sfr_pkg::*;

   localparam int MC_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int HELD_N = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

   logic [MC_W-1:0] mc_ff;
   logic [MC_W-1:0] mc_in;
   logic [7:0]      held_ff [HELD_N];

   logic             accept;
   logic [LEN_W-1:0] plen;
   logic [LEN_W-1:0] rlen;
   logic [MC_W+2:0]  pb_sel;
   logic [7:0]       pb;
   logic             same;
   logic             complete;
   logic             hold_byte;
   logic [8*CMD_LANES-1:0] pass_data;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
      return c;
   endfunction

   assign accept = req_push && !q_full;

   // Clamp the lengths to what the hardware holds
   always_comb begin
      if (cfg.pattern_length == '0)
         plen = LEN_W'(1);
      else if (cfg.pattern_length > LEN_W'(PATTERN_MAX))
         plen = LEN_W'(PATTERN_MAX);
      else
         plen = cfg.pattern_length;
      if (cfg.replacement_length > LEN_W'(REPLACEMENT_MAX))
         rlen = LEN_W'(REPLACEMENT_MAX);
      else
         rlen = cfg.replacement_length;
   end

   // Compare against the next pattern byte
   assign pb_sel    = {mc_ff, 3'b000};
   assign pb        = cfg.pattern_bytes[pb_sel +: 8];
   assign same      = cfg.match_case ? (req_in_byte == pb)
                                     : (fold_case(req_in_byte) == fold_case(pb));
   assign complete  = (LEN_W'(mc_ff) + LEN_W'(1)) >= plen;
   assign hold_byte = same && !complete;

   // Pass-through lanes: held bytes below the match count, then this byte
   for (genvar k = 0; k < CMD_LANES; k++) begin : g_lane
      if (k < HELD_N) begin : g_held
         assign pass_data[8*k +: 8] = (MC_W'(k) < mc_ff) ? held_ff[k] : req_in_byte;
      end else begin : g_byte
         assign pass_data[8*k +: 8] = req_in_byte;
      end
   end

   // Build the command
   always_comb begin
      cmd_rep   = 1'b0;
      cmd_count = CNT_W'(mc_ff) + CNT_W'(1);
      cmd_data  = pass_data;
      cmd_push  = 1'b0;
      if (same && complete) begin
         cmd_rep   = 1'b1;
         cmd_count = CNT_W'(rlen);
         cmd_data  = (8*CMD_LANES)'(cfg.replacement_bytes);
         cmd_push  = accept && (rlen != '0);
      end else if (!same || req_end_of_stream) begin
         cmd_push = accept;
      end
   end

   // Advance the match count
   always_comb begin
      mc_in = mc_ff;
      if (accept) begin
         if (hold_byte && !req_end_of_stream)
            mc_in = mc_ff + MC_W'(1);
         else
            mc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff <= '0;
      end else begin
         mc_ff <= mc_in;
      end
   end

   // Store the byte of a partial match
   always_ff @(posedge clock) begin
      for (int k = 0; k < HELD_N; k++) begin
         if (accept && hold_byte && mc_ff == MC_W'(k))
            held_ff[k] <= req_in_byte;
      end
   end

   a_cmd_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd_count != '0))
      else $error("front pushed a command with no bytes");

endmodule

// ----- rtl/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue: command queue
// Short register queue between the match tracker and the output sequencer.
// ----------------------------------------------------------------------------
module sfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import sfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (!push && do_pop)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

// ----- rtl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back: output sequencer
// Walks the head command byte by byte into the output register and drops
// the command after its last byte, marking that byte as the end of the run.
// ----------------------------------------------------------------------------
module sfr_back #(
   parameter int CMD_LANES = sfr_pkg::PATTERN_MAX_DEF,
   parameter int CNT_W     = $clog2(CMD_LANES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  logic                   head_rep,
   input  logic [CNT_W-1:0]       head_count,
   input  logic [8*CMD_LANES-1:0] head_data,
   output logic                   deq,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_from_replacement,
   output logic                   rsp_last_of_run
);
   import sfr_pkg::*;

   localparam int LANE_W = (CMD_LANES > 1) ? $clog2(CMD_LANES) : 1;

   logic [LANE_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff;
   logic              rep_ff;
   logic              last_ff;
   logic              load;
   logic              is_last;
   logic [LANE_W+2:0] sel;

   assign load    = head_valid && (!valid_ff || rsp_pop);
   assign is_last = (CNT_W'(idx_ff) + CNT_W'(1)) == head_count;
   assign deq     = load && is_last;
   assign sel     = {idx_ff, 3'b000};

   // Step through the head command
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (rsp_pop)
         valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + LANE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_data[sel +: 8];
         rep_ff  <= head_rep;
         last_ff <= is_last;
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_from_replacement = rep_ff;
   assign rsp_last_of_run      = last_ff;

   a_mid_cmd_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> head_valid)
      else $error("sequencer mid-command with no command at head");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> (CNT_W'(idx_ff) < head_count))
      else $error("sequencer index past command length");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream find-and-replace block
// Pushes directed and random byte streams through the block under several
// pattern/replacement settings, predicts each output byte with a local
// model of the matcher, and checks the output stream byte by byte.
// ----------------------------------------------------------------------------
module testbench;
   import sfr_pkg::*;

   localparam int PAT_MAX      = 8;
   localparam int REP_MAX      = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_ITEMS  = 48;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       eos;
   } byte_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       from_rep;
      logic       last;
   } out_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   req_end_of_stream = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_from_replacement;
   logic                   rsp_last_of_run;

   // Requests waiting to be pushed, and output bytes still owed by the block
   byte_req_type byte_requests[$];
   out_item_type out_stream_q[$];

   // Shadow configuration and match state of the predictor
   logic [63:0]      cfg_pat   = '0;
   logic [LEN_W-1:0] cfg_plen  = 4'd1;
   logic [63:0]      cfg_rep   = '0;
   logic [LEN_W-1:0] cfg_rlen  = 4'd0;
   logic             cfg_exact = 1'b0;
   int               match_len = 0;
   logic [7:0]       held[PAT_MAX];

   int   err_count  = 0;
   int   items_made = 0;
   logic no_gaps    = 1'b0;

   stream_find_replace dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_in_byte          (req_in_byte),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_from_replacement (rsp_from_replacement),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_error(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      err_count++;
   endtask

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic int eff_plen();
      if (cfg_plen == 0)
         return 1;
      return (cfg_plen > PAT_MAX) ? PAT_MAX : int'(cfg_plen);
   endfunction

   // Advance the matcher by one request and queue the bytes it releases
   task automatic find_replace_step(input logic [7:0] in_b, input logic eos);
      int           plen;
      int           rlen;
      logic [7:0]   pat_b;
      logic         hit;
      out_item_type burst[$];
      plen  = eff_plen();
      rlen  = (cfg_rlen > REP_MAX) ? REP_MAX : int'(cfg_rlen);
      pat_b = cfg_pat[8*match_len +: 8];
      hit   = cfg_exact ? (in_b == pat_b) : (lower_ascii(in_b) == lower_ascii(pat_b));
      if (hit) begin
         if (match_len + 1 >= plen) begin
            for (int i = 0; i < rlen; i++)
               burst.push_back(out_item_type'{cfg_rep[8*i +: 8], 1'b1, 1'b0});
            match_len = 0;
         end else begin
            held[match_len] = in_b;
            match_len++;
         end
      end else begin
         for (int i = 0; i < match_len; i++)
            burst.push_back(out_item_type'{held[i], 1'b0, 1'b0});
         burst.push_back(out_item_type'{in_b, 1'b0, 1'b0});
         match_len = 0;
      end
      // Flush whatever is still held at end of stream
      if (eos) begin
         for (int i = 0; i < match_len; i++)
            burst.push_back(out_item_type'{held[i], 1'b0, 1'b0});
         match_len = 0;
      end
      if (burst.size() != 0)
         burst[burst.size()-1].last = 1'b1;
      foreach (burst[i])
         out_stream_q.push_back(burst[i]);
   endtask

   // Drive request and pop; offer the head request, with random gaps, until it is taken
   always @(negedge clock) begin
      if (byte_requests.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
         req_push          <= 1'b1;
         req_in_byte       <= byte_requests[0].in_byte;
         req_end_of_stream <= byte_requests[0].eos;
      end else begin
         req_push          <= 1'b0;
         req_in_byte       <= 8'($urandom);
         req_end_of_stream <= 1'($urandom);
      end
      rsp_pop <= no_gaps || ($urandom_range(0, 99) >= 10);
   end

   // Predict on each accepted request, check each popped output byte
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && req_push && !req_full) begin
         find_replace_step(req_in_byte, req_end_of_stream);
         byte_requests.delete(0);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (out_stream_q.size() == 0) begin
            report_error($sformatf("unexpected output byte %h", rsp_out_byte));
         end else begin
            want = out_stream_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_error($sformatf("out_byte %h, want %h", rsp_out_byte, want.out_byte));
            if (rsp_from_replacement !== want.from_rep)
               report_error($sformatf("from_replacement %b, want %b (byte %h)",
                                      rsp_from_replacement, want.from_rep, want.out_byte));
            if (rsp_last_of_run !== want.last)
               report_error($sformatf("last_of_run %b, want %b (byte %h)",
                                      rsp_last_of_run, want.last, want.out_byte));
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic eos);
      byte_requests.push_back(byte_req_type'{b, eos});
      items_made++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_PATTERN_BYTES:      cfg_pat   = data;
         CSR_PATTERN_LENGTH:     cfg_plen  = data[LEN_W-1:0];
         CSR_REPLACEMENT_BYTES:  cfg_rep   = data;
         CSR_REPLACEMENT_LENGTH: cfg_rlen  = data[LEN_W-1:0];
         CSR_MATCH_CASE:         cfg_exact = data[0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [63:0] pat, input logic [3:0] plen,
                              input logic [63:0] rep, input logic [3:0] rlen,
                              input logic exact);
      write_csr(CSR_PATTERN_BYTES, pat);
      write_csr(CSR_PATTERN_LENGTH, {60'd0, plen});
      write_csr(CSR_REPLACEMENT_BYTES, rep);
      write_csr(CSR_REPLACEMENT_LENGTH, {60'd0, rlen});
      write_csr(CSR_MATCH_CASE, {63'd0, exact});
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Hold until every owed byte has come out and the pipeline has settled
   task automatic wait_quiet();
      do
         @(posedge clock);
      while (byte_requests.size() != 0 || out_stream_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] near_letter();
      return 8'h40 + 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [63:0] make_pattern();
      logic [63:0] p;
      for (int k = 0; k < 8; k++)
         p[8*k +: 8] = ($urandom_range(0, 99) < 75) ? near_letter() : 8'($urandom);
      return p;
   endfunction

   // Flip the case of a letter at random when compare ignores case
   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if (!cfg_exact && lower_ascii(b) >= 8'h61 && lower_ascii(b) <= 8'h7A
          && $urandom_range(0, 1) == 1)
         return b ^ 8'h20;
      return b;
   endfunction

   // One random run: a full occurrence, a broken prefix, or a stray byte
   task automatic random_run();
      int pl;
      int sel;
      int n;
      pl  = eff_plen();
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         for (int k = 0; k < pl; k++)
            queue_byte(vary_case(cfg_pat[8*k +: 8]), $urandom_range(0, 99) < 5);
      end else if (sel < 75 && pl > 1) begin
         n = $urandom_range(1, pl - 1);
         for (int k = 0; k < n; k++)
            queue_byte(vary_case(cfg_pat[8*k +: 8]), $urandom_range(0, 99) < 5);
         queue_byte($urandom_range(0, 1) ? near_letter() : 8'($urandom),
                    $urandom_range(0, 99) < 5);
      end else begin
         queue_byte($urandom_range(0, 1) ? near_letter() : 8'($urandom),
                    $urandom_range(0, 99) < 5);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero byte matches, empty replacement swallows it
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_quiet();

      // Case-insensitive three-byte pattern
      load_config(64'h0000_0000_0043_6241, 4'd3, 64'h2E2D_2C2B_2A29_7A79, 4'd2, 1'b0);
      queue_byte("a", 1'b0); queue_byte("B", 1'b0); queue_byte("c", 1'b0);
      queue_byte("a", 1'b0); queue_byte("b", 1'b0); queue_byte("x", 1'b0);
      // Second byte breaks the match and is not retried as a new start
      queue_byte("a", 1'b0); queue_byte("a", 1'b0);
      // Flush a partial match at end of stream
      queue_byte("A", 1'b0); queue_byte("B", 1'b1);
      // Leave a partial match open across a configuration change
      queue_byte("a", 1'b0); queue_byte("b", 1'b0);
      wait_quiet();
      load_config(64'h0000_0000_0043_6241, 4'd2, 64'hFFEE_DDCC_BBAA_9988, 4'd15, 1'b0);
      queue_byte("c", 1'b0);
      wait_quiet();

      // Zero pattern length acts as one; exact compare
      load_config(64'h0000_0000_0000_0041, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
      queue_byte("a", 1'b0); queue_byte("A", 1'b0);
      wait_quiet();

      // Oversized pattern length saturates; bytes next to the letter range
      load_config(64'h4161_5A7A_7B60_5B40, 4'd15, 64'h0, 4'd1, 1'b0);
      queue_byte(8'h40, 1'b0); queue_byte(8'h5B, 1'b0);
      queue_byte(8'h60, 1'b0); queue_byte(8'h7B, 1'b0);
      queue_byte("Z", 1'b0); queue_byte("z", 1'b0);
      queue_byte("A", 1'b0); queue_byte("a", 1'b1);
      wait_quiet();

      // Random phases, each under its own settings
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: load_config(make_pattern(), 4'($urandom_range(1, 8)),
                           {$urandom, $urandom}, 4'($urandom_range(0, 8)), 1'b0);
            1: load_config({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8, 1'b1);
            2: load_config(make_pattern(), 4'($urandom_range(1, 3)),
                           {$urandom, $urandom}, 4'($urandom_range(0, 8)),
                           1'($urandom));
            3: load_config({64{1'b1}}, 4'd15, 64'h0, 4'd15, 1'b1);
            4: load_config(make_pattern(), 4'd0, {64{1'b1}}, 4'd0, 1'b1);
            default: load_config(make_pattern(), 4'($urandom_range(0, 15)),
                                 {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                                 1'($urandom));
         endcase
         no_gaps   = (ph == 2);
         items_made = 0;
         while (items_made < PHASE_ITEMS)
            random_run();
         wait_quiet();
         no_gaps = 1'b0;
      end

      if (err_count == 0 && out_stream_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sfr_pkg.sv
rtl/sfr_csr.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace.sv
dv/testbench.sv
